[design/swept_rect_collision_bisect_unit_macros.svh]
// Assertion helpers used by the collision pipeline's trial stage.
`ifndef SWEPT_RECT_COLLISION_BISECT_UNIT_MACROS_SVH
`define SWEPT_RECT_COLLISION_BISECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRCB_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("srcb: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SRCB_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("srcb: next-cycle check failed");

`endif

[design/srcb_pkg.sv]
package srcb_pkg;

  // Geometry and trial count
  localparam int COORD_BITS = 16;
  localparam int TRIALS     = 4;

  // Trial displacement reaches almost twice the request
  localparam int TD_W  = COORD_BITS + 2;
  // Edge plus trial displacement
  localparam int S_W   = COORD_BITS + 3;
  // Fraction numerator, odd, below 2^(TRIALS+1)
  localparam int NUM_W = TRIALS + 1;
  // Displacement times numerator
  localparam int P_W   = COORD_BITS + NUM_W + 1;
  // Denominator exponent, 0..TRIALS
  localparam int SH_W  = $clog2(TRIALS + 1);

  // Contact flag positions
  localparam int HIT_RIGHT  = 0;
  localparam int HIT_LEFT   = 1;
  localparam int HIT_BOTTOM = 2;
  localparam int HIT_TOP    = 3;
  localparam int HIT_W      = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TD_W-1:0]       td_t;
  typedef logic signed [S_W-1:0]        sum_t;
  typedef logic signed [P_W-1:0]        prod_t;
  typedef logic [NUM_W-1:0]             num_t;
  typedef logic [SH_W-1:0]              sh_t;
  typedef logic [HIT_W-1:0]             hit_t;

  typedef struct packed {
    coord_t mover_left;
    coord_t mover_top;
    coord_t mover_right;
    coord_t mover_bottom;
    coord_t move_dx;
    coord_t move_dy;
    coord_t target_left;
    coord_t target_top;
    coord_t target_right;
    coord_t target_bottom;
  } in_word_t;

  typedef struct packed {
    hit_t   hit_sides;
    coord_t safe_dx;
    coord_t safe_dy;
  } out_word_t;

  // Per-item state carried down the trial stages
  typedef struct packed {
    coord_t ml;
    coord_t mt;
    coord_t mr;
    coord_t mb;
    coord_t tl;
    coord_t tt;
    coord_t tr;
    coord_t tb;
    coord_t dx;
    coord_t dy;
    hit_t   en;
    td_t    tdx;
    td_t    tdy;
    td_t    sdx;
    td_t    sdy;
    hit_t   flags;
    num_t   num;
    sh_t    sh;
  } trial_word_t;

  function automatic sum_t ext_coord(input coord_t v);
    return {{(S_W-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic sum_t ext_td(input td_t v);
    return {{(S_W-TD_W){v[TD_W-1]}}, v};
  endfunction

  function automatic td_t coord_to_td(input coord_t v);
    return {{(TD_W-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

endpackage

[design/srcb_if.sv]
interface srcb_in_if import srcb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srcb_out_if import srcb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/srcb_prep.sv]
module srcb_prep import srcb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  srcb_in_if.sink     in_ch,
  output logic        dn_valid,
  input  logic        dn_ready,
  output trial_word_t dn_word
);

  logic        valid_r;
  trial_word_t word_r;
  trial_word_t word_nxt;
  logic        take;
  logic        h_ok;
  logic        v_ok;
  coord_t      ml, mt, mr, mb, tl, tt, tr, tb;

  assign in_ch.ready = !valid_r || dn_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Trial-independent side conditions, seed the first trial
  always_comb begin
    ml = in_ch.data.mover_left;
    mt = in_ch.data.mover_top;
    mr = in_ch.data.mover_right;
    mb = in_ch.data.mover_bottom;
    tl = in_ch.data.target_left;
    tt = in_ch.data.target_top;
    tr = in_ch.data.target_right;
    tb = in_ch.data.target_bottom;
    h_ok = (mb > tt) && (tb > mt);
    v_ok = (mr > tl) && (tr > ml);

    word_nxt                 = '0;
    word_nxt.ml              = ml;
    word_nxt.mt              = mt;
    word_nxt.mr              = mr;
    word_nxt.mb              = mb;
    word_nxt.tl              = tl;
    word_nxt.tt              = tt;
    word_nxt.tr              = tr;
    word_nxt.tb              = tb;
    word_nxt.dx              = in_ch.data.move_dx;
    word_nxt.dy              = in_ch.data.move_dy;
    word_nxt.en[HIT_RIGHT]   = h_ok && (ml > tl);
    word_nxt.en[HIT_LEFT]    = h_ok && (tr > mr);
    word_nxt.en[HIT_BOTTOM]  = v_ok && (mt > tt);
    word_nxt.en[HIT_TOP]     = v_ok && (tb > mb);
    word_nxt.tdx             = coord_to_td(in_ch.data.move_dx);
    word_nxt.tdy             = coord_to_td(in_ch.data.move_dy);
    word_nxt.num             = num_t'(1);
  end

  // Advance valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  // Capture word
  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

[design/srcb_trial.sv]
`include "swept_rect_collision_bisect_unit_macros.svh"

module srcb_trial import srcb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  trial_word_t up_word,
  output logic        dn_valid,
  input  logic        dn_ready,
  output trial_word_t dn_word
);

  // Test stage
  logic        t_valid_r;
  trial_word_t t_r;
  trial_word_t t_nxt;
  logic        t_ready_up;
  hit_t        hit_v;
  logic        hit;
  sum_t        nl, nr, nt, nb;

  // Scale stage
  logic        s_valid_r;
  trial_word_t s_r;
  trial_word_t s_nxt;
  logic        s_ready_up;
  prod_t       dx_e, dy_e, num_e;
  prod_t       px, py;
  prod_t       bias;
  prod_t       qx, qy;

  assign s_ready_up = !s_valid_r || dn_ready;
  assign t_ready_up = !t_valid_r || s_ready_up;
  assign up_ready   = t_ready_up;

  // Offset the original mover and run the four side tests
  always_comb begin
    nl = ext_coord(up_word.ml) + ext_td(up_word.tdx);
    nr = ext_coord(up_word.mr) + ext_td(up_word.tdx);
    nt = ext_coord(up_word.mt) + ext_td(up_word.tdy);
    nb = ext_coord(up_word.mb) + ext_td(up_word.tdy);
    hit_v[HIT_RIGHT]  = up_word.en[HIT_RIGHT]  && (ext_coord(up_word.tr) > nl);
    hit_v[HIT_LEFT]   = up_word.en[HIT_LEFT]   && (nr > ext_coord(up_word.tl));
    hit_v[HIT_BOTTOM] = up_word.en[HIT_BOTTOM] && (ext_coord(up_word.tb) > nt);
    hit_v[HIT_TOP]    = up_word.en[HIT_TOP]    && (nb > ext_coord(up_word.tt));
    hit = |hit_v;

    t_nxt       = up_word;
    t_nxt.flags = up_word.flags | hit_v;
    t_nxt.sh    = up_word.sh + sh_t'(1);
    if (hit) begin
      t_nxt.num = {up_word.num[NUM_W-2:0], 1'b0} - num_t'(1);
    end else begin
      t_nxt.num = {up_word.num[NUM_W-2:0], 1'b1};
      t_nxt.sdx = up_word.tdx;
      t_nxt.sdy = up_word.tdy;
    end
  end

  // Next trial displacement: move * num / 2^sh, truncated toward zero
  always_comb begin
    dx_e  = {{(P_W-COORD_BITS){t_r.dx[COORD_BITS-1]}}, t_r.dx};
    dy_e  = {{(P_W-COORD_BITS){t_r.dy[COORD_BITS-1]}}, t_r.dy};
    num_e = {{(P_W-NUM_W){1'b0}}, t_r.num};
    px    = dx_e * num_e;
    py    = dy_e * num_e;
    bias  = (prod_t'(1) <<< t_r.sh) - prod_t'(1);
    qx    = (px + (px[P_W-1] ? bias : prod_t'(0))) >>> t_r.sh;
    qy    = (py + (py[P_W-1] ? bias : prod_t'(0))) >>> t_r.sh;

    s_nxt     = t_r;
    s_nxt.tdx = qx[TD_W-1:0];
    s_nxt.tdy = qy[TD_W-1:0];
  end

  // Advance test stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
    end else if (t_ready_up) begin
      t_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && t_ready_up) begin
      t_r <= t_nxt;
    end
  end

  // Advance scale stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (s_ready_up) begin
      s_valid_r <= t_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (t_valid_r && s_ready_up) begin
      s_r <= s_nxt;
    end
  end

  assign dn_valid = s_valid_r;
  assign dn_word  = s_r;

  // The numerator stays odd after every decision
  `SRCB_ASSERT_IMP(a_num_odd, clk, rst_n, t_valid_r, t_r.num[0])
  // A trial without a hit leaves num = 3 mod 4 and records its displacement
  `SRCB_ASSERT_IMP(a_safe_on_miss, clk, rst_n, t_valid_r && t_r.num[1], (t_r.sdx == t_r.tdx) && (t_r.sdy == t_r.tdy))
  // Denominator exponent has moved past zero once a trial is done
  `SRCB_ASSERT_IMP(a_sh_nonzero, clk, rst_n, t_valid_r, t_r.sh != '0)
  // A blocked test stage holds its word
  `SRCB_ASSERT_NXT(a_hold_on_stall, clk, rst_n, t_valid_r && !s_ready_up, t_valid_r && $stable(t_r))

endmodule

[design/srcb_out.sv]
module srcb_out import srcb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  trial_word_t up_word,
  srcb_out_if.source  out_ch
);

  logic      valid_r;
  out_word_t word_r;
  out_word_t word_nxt;

  // Clamp a trial displacement to the coordinate range
  function automatic coord_t sat_coord(input td_t v);
    coord_t res;
    res = v[COORD_BITS-1:0];
    if (!v[TD_W-1] && (|v[TD_W-2:COORD_BITS-1])) begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (v[TD_W-1] && !(&v[TD_W-2:COORD_BITS-1])) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end
    return res;
  endfunction

  assign up_ready = !valid_r || out_ch.ready;

  always_comb begin
    word_nxt.hit_sides = up_word.flags;
    word_nxt.safe_dx   = sat_coord(up_word.sdx);
    word_nxt.safe_dy   = sat_coord(up_word.sdy);
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.data  = word_r;

endmodule

[design/swept_rect_collision_bisect_unit.sv]
// Channel  Dir  Payload                                        Handshake
// in_ch    in   mover edges, move_dx/dy, target edges          valid/ready
// out_ch   out  hit_sides, safe_dx, safe_dy                    valid/ready
//
// One word enters per cycle while in_ch.ready is high; each result passes
// through one input stage, a test and a scale stage per trial, and the
// output register.
// The scale stage's small multiplier sets the stage depth.
// rst_n is synchronous, active low, and clears only the valid bits.
// Each stage takes a new word when it is empty or its successor moves, so a
// stalled output fills the bubbles before in_ch.ready drops.
module swept_rect_collision_bisect_unit import srcb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srcb_in_if.sink    in_ch,
  srcb_out_if.source out_ch
);

  logic        st_valid [TRIALS+1];
  logic        st_ready [TRIALS+1];
  trial_word_t st_word  [TRIALS+1];

  // Register the input word and precompute side enables
  srcb_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_word  (st_word[0])
  );

  // One test-and-scale pair per trial
  for (genvar g = 0; g < TRIALS; g++) begin : g_trial
    srcb_trial u_trial (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[g]),
      .up_ready (st_ready[g]),
      .up_word  (st_word[g]),
      .dn_valid (st_valid[g+1]),
      .dn_ready (st_ready[g+1]),
      .dn_word  (st_word[g+1])
    );
  end

  // Saturate and hold the result
  srcb_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (st_valid[TRIALS]),
    .up_ready (st_ready[TRIALS]),
    .up_word  (st_word[TRIALS]),
    .out_ch   (out_ch)
  );

endmodule
